// ===== design/rhc_pkg.sv =====
package rhc_pkg;

    // default sizes of the bin store and sample path
    localparam int NUM_BINS_DEF     = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 32;

    // fixed field widths
    localparam int FUNC_W      = 2;
    localparam int INDEX_W     = 6;
    localparam int RANGE_W     = 16;
    localparam int BWIDTH_W    = 16;
    localparam int BCOUNT_W    = 7;
    localparam int TOTAL_W     = 32;
    localparam int OUT_EDGE_W  = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_COUNT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = 2'd2;

    // configuration reset values
    localparam logic [RANGE_W-1:0]  RANGE_LOW_RST = 16'd0;
    localparam logic [BWIDTH_W-1:0] BIN_WIDTH_RST = 16'd1;
    localparam logic [BCOUNT_W-1:0] BIN_COUNT_RST = 7'd64;

    // control part of a transaction travelling down the cell row
    typedef struct packed {
        logic                vld;
        logic [FUNC_W-1:0]   func;
        logic [INDEX_W-1:0]  index;
        logic                ok;
    } rhc_ctl_t;

endpackage

// ===== design/rhc_cell.sv =====
module rhc_cell #(
    parameter int NUM_BINS     = rhc_pkg::NUM_BINS_DEF,
    parameter int CELL_IDX     = 0,
    parameter int SAMPLE_WIDTH = rhc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = rhc_pkg::COUNT_WIDTH_DEF,
    parameter int EDGE_WIDTH   = 25
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rhc_pkg::rhc_ctl_t                    ctl_in,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
    input  logic        [COUNT_WIDTH-1:0]        total_in,
    input  logic signed [EDGE_WIDTH-1:0]         lo_in,
    input  logic signed [EDGE_WIDTH-1:0]         hi_in,
    input  logic signed [EDGE_WIDTH-1:0]         edge_in,
    input  logic        [rhc_pkg::BWIDTH_W-1:0]  bin_width,
    input  logic        [rhc_pkg::BCOUNT_W-1:0]  bin_count,
    output rhc_pkg::rhc_ctl_t                    ctl_out,
    output logic signed [SAMPLE_WIDTH-1:0]       sample_out,
    output logic        [COUNT_WIDTH-1:0]        total_out,
    output logic signed [EDGE_WIDTH-1:0]         lo_out,
    output logic signed [EDGE_WIDTH-1:0]         hi_out,
    output logic signed [EDGE_WIDTH-1:0]         edge_out
);

    localparam int NBW = $clog2(NUM_BINS + 1);
    localparam int CIW = (NBW > rhc_pkg::BCOUNT_W) ? NBW : rhc_pkg::BCOUNT_W;
    localparam int CMW = ((EDGE_WIDTH > SAMPLE_WIDTH) ? EDGE_WIDTH : SAMPLE_WIDTH) + 1;

    rhc_pkg::rhc_ctl_t                 ctl_reg,    ctl_next;
    logic signed [SAMPLE_WIDTH-1:0]    sample_reg;
    logic        [COUNT_WIDTH-1:0]     total_reg,  total_next;
    logic signed [EDGE_WIDTH-1:0]      lo_reg,     lo_next;
    logic signed [EDGE_WIDTH-1:0]      hi_reg,     hi_next;
    logic signed [EDGE_WIDTH-1:0]      edge_reg;
    logic        [COUNT_WIDTH-1:0]     count_reg,  count_next;
    logic signed [EDGE_WIDTH-1:0]      edge_hi;
    logic signed [CMW-1:0]             s_ext;
    logic signed [CMW-1:0]             lo_ext;
    logic signed [CMW-1:0]             hi_ext;
    logic                              active;
    logic                              hit;
    logic                              sel;

    // upper edge of this bin, also the lower edge of the next one
    assign edge_hi  = edge_reg + EDGE_WIDTH'($signed({1'b0, bin_width}));
    assign edge_out = edge_hi;

    // bin in use and strict interior test
    assign active = CIW'(CELL_IDX) < CIW'(bin_count);
    assign s_ext  = CMW'(sample_in);
    assign lo_ext = CMW'(edge_reg);
    assign hi_ext = CMW'(edge_hi);
    assign hit    = active && (s_ext > lo_ext) && (s_ext < hi_ext);
    assign sel    = CIW'(ctl_in.index) == CIW'(CELL_IDX);

    // count update and read capture
    always_comb
    begin
        count_next = count_reg;
        ctl_next   = ctl_in;
        total_next = total_in;
        lo_next    = lo_in;
        hi_next    = hi_in;
        if (ctl_in.vld)
        begin
            case (ctl_in.func)
                rhc_pkg::FUNC_COUNT:
                begin
                    if (hit && (count_reg != {COUNT_WIDTH{1'b1}}))
                    begin
                        count_next = count_reg + COUNT_WIDTH'(1);
                    end
                end
                rhc_pkg::FUNC_CLEAR:
                begin
                    count_next = '0;
                end
                rhc_pkg::FUNC_READ:
                begin
                    if (sel)
                    begin
                        ctl_next.ok = active;
                        total_next  = active ? count_reg : '0;
                        lo_next     = active ? edge_reg : '0;
                        hi_next     = active ? edge_hi : '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // control and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            ctl_reg   <= ctl_next;
            count_reg <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_in;
        total_reg  <= total_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        edge_reg   <= edge_in;
    end

    assign ctl_out    = ctl_reg;
    assign sample_out = sample_reg;
    assign total_out  = total_reg;
    assign lo_out     = lo_reg;
    assign hi_out     = hi_reg;

endmodule

// ===== design/regular_histogram_counter.sv =====
// Fixed-width histogram: counts signed samples into equal-width bins.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low. func 0 counts sample_value, func 1 reads bin bin_index,
// func 2 clears every count, func 3 does nothing.
// Each transaction walks a row of NUM_BINS cells, one cell per cycle; every
// cell holds one count and its lower edge. A new transaction can be taken in
// every cycle while busy is low.
// A read returns its result at the end of the row, for one cycle
// with result_valid high; the receiver cannot stall, so results never wait.
// Count and clear transactions produce no result.
// Configuration: cfg_valid/cfg_ready write register cfg_index (0 range_low,
// 1 bin_width, 2 bin_count). cfg_ready is low while any transaction is
// still in the row. After a write, busy stays high while the new bin edges
// ripple down the row.
// Reset clears all counts, loads default configuration and holds busy high
// while the reset edges settle.
module regular_histogram_counter #(
    parameter int NUM_BINS     = rhc_pkg::NUM_BINS_DEF,
    parameter int SAMPLE_WIDTH = rhc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = rhc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic        [rhc_pkg::FUNC_W-1:0]     func,
    input  logic signed [SAMPLE_WIDTH-1:0]        sample_value,
    input  logic        [rhc_pkg::INDEX_W-1:0]    bin_index,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [rhc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [rhc_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                                  result_valid,
    output logic        [rhc_pkg::TOTAL_W-1:0]    bin_total,
    output logic signed [rhc_pkg::OUT_EDGE_W-1:0] edge_low,
    output logic signed [rhc_pkg::OUT_EDGE_W-1:0] edge_high,
    output logic                                  index_ok
);

    localparam int EW  = 18 + $clog2(NUM_BINS + 1);
    localparam int STW = $clog2(NUM_BINS + 1);

    logic signed [rhc_pkg::RANGE_W-1:0]  range_low_reg;
    logic        [rhc_pkg::BWIDTH_W-1:0] bin_width_reg;
    logic        [rhc_pkg::BCOUNT_W-1:0] bin_count_reg;
    logic        [STW-1:0]               settle_reg, settle_next;
    logic                                accept;
    logic                                cfg_write;

    rhc_pkg::rhc_ctl_t                   ctl_c    [NUM_BINS+1];
    logic signed [SAMPLE_WIDTH-1:0]      sample_c [NUM_BINS+1];
    logic        [COUNT_WIDTH-1:0]       total_c  [NUM_BINS+1];
    logic signed [EW-1:0]                lo_c     [NUM_BINS+1];
    logic signed [EW-1:0]                hi_c     [NUM_BINS+1];
    logic signed [EW-1:0]                edge_c   [NUM_BINS+1];
    logic        [NUM_BINS-1:0]          stage_vld;

    assign accept    = start && !busy;
    assign busy      = settle_reg != '0;
    assign cfg_ready = !(|stage_vld) && !accept;
    assign cfg_write = cfg_valid && cfg_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg <= rhc_pkg::RANGE_LOW_RST;
            bin_width_reg <= rhc_pkg::BIN_WIDTH_RST;
            bin_count_reg <= rhc_pkg::BIN_COUNT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rhc_pkg::REG_RANGE_LOW: range_low_reg <= cfg_data;
                rhc_pkg::REG_BIN_WIDTH: bin_width_reg <= cfg_data;
                rhc_pkg::REG_BIN_COUNT: bin_count_reg <= cfg_data[rhc_pkg::BCOUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // edge settle counter
    always_comb
    begin
        settle_next = settle_reg;
        if (cfg_write)
        begin
            settle_next = STW'(NUM_BINS);
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - STW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= STW'(NUM_BINS);
        end
        else
        begin
            settle_reg <= settle_next;
        end
    end

    // entry of the cell row
    assign ctl_c[0]    = '{vld: accept, func: func, index: bin_index, ok: 1'b0};
    assign sample_c[0] = sample_value;
    assign total_c[0]  = '0;
    assign lo_c[0]     = '0;
    assign hi_c[0]     = '0;
    assign edge_c[0]   = EW'(range_low_reg);

    // row of bin cells
    for (genvar i = 0; i < NUM_BINS; i++)
    begin : g_cell
        rhc_cell #(
            .NUM_BINS     (NUM_BINS),
            .CELL_IDX     (i),
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .COUNT_WIDTH  (COUNT_WIDTH),
            .EDGE_WIDTH   (EW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl_in     (ctl_c[i]),
            .sample_in  (sample_c[i]),
            .total_in   (total_c[i]),
            .lo_in      (lo_c[i]),
            .hi_in      (hi_c[i]),
            .edge_in    (edge_c[i]),
            .bin_width  (bin_width_reg),
            .bin_count  (bin_count_reg),
            .ctl_out    (ctl_c[i+1]),
            .sample_out (sample_c[i+1]),
            .total_out  (total_c[i+1]),
            .lo_out     (lo_c[i+1]),
            .hi_out     (hi_c[i+1]),
            .edge_out   (edge_c[i+1])
        );
        assign stage_vld[i] = ctl_c[i+1].vld;
    end

    // result from the end of the row
    assign result_valid = ctl_c[NUM_BINS].vld && (ctl_c[NUM_BINS].func == rhc_pkg::FUNC_READ);
    assign index_ok     = ctl_c[NUM_BINS].ok;

    if (COUNT_WIDTH > rhc_pkg::TOTAL_W)
    begin : g_total_sat
        assign bin_total = (|total_c[NUM_BINS][COUNT_WIDTH-1:rhc_pkg::TOTAL_W])
                         ? {rhc_pkg::TOTAL_W{1'b1}}
                         : total_c[NUM_BINS][rhc_pkg::TOTAL_W-1:0];
    end
    else
    begin : g_total_ext
        assign bin_total = rhc_pkg::TOTAL_W'(total_c[NUM_BINS]);
    end

    if (EW >= rhc_pkg::OUT_EDGE_W)
    begin : g_edge_trunc
        assign edge_low  = lo_c[NUM_BINS][rhc_pkg::OUT_EDGE_W-1:0];
        assign edge_high = hi_c[NUM_BINS][rhc_pkg::OUT_EDGE_W-1:0];
    end
    else
    begin : g_edge_ext
        assign edge_low  = rhc_pkg::OUT_EDGE_W'(lo_c[NUM_BINS]);
        assign edge_high = rhc_pkg::OUT_EDGE_W'(hi_c[NUM_BINS]);
    end

endmodule
